// ===== design/blr_pkg.sv =====
// Shared constants, types and the sequencer states of the line rasteriser.
package blr_pkg;

	localparam int COORD_BITS = 6;
	localparam int DEC_BITS   = COORD_BITS + 3;
	localparam int DIM_BITS   = 7;
	localparam int COLOR_BITS = 24;
	localparam int IN_BITS    = 4 * COORD_BITS + COLOR_BITS;
	localparam int OUT_RAW    = 2 * COORD_BITS + COLOR_BITS;
	localparam int OUT_BITS   = ((OUT_RAW + 7) / 8) * 8;
	localparam int ADDR_BITS  = 3;
	localparam int APB_BITS   = 32;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(64);

	typedef logic [COORD_BITS-1:0]      coord_t;
	typedef logic signed [DEC_BITS-1:0] dec_t;
	typedef logic [DIM_BITS-1:0]        dim_t;
	typedef logic [COLOR_BITS-1:0]      color_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIFF,
		ST_INIT,
		ST_RUN
	} blr_state_t;

	// Walk state: decision term and the two coordinates along the major and minor axes.
	typedef struct packed {
		dec_t   q;
		coord_t maj;
		coord_t mnr;
	} blr_walk_t;

	// Constant terms of one line, fixed during set-up.
	typedef struct packed {
		dec_t inc_a;
		dec_t inc_b;
		logic mnr_dec;
	} blr_terms_t;

endpackage

// ===== design/blr_step_unit.sv =====
// Step unit: a decision-term update, a major step, and a minor step when q > 0.
module blr_step_unit (
	input  blr_pkg::blr_walk_t  cur,
	input  blr_pkg::blr_terms_t terms,
	output blr_pkg::blr_walk_t  nxt
);
	import blr_pkg::*;

	logic move;

	assign move = (cur.q > 0);

	always_comb begin
		nxt.maj = cur.maj + coord_t'(1);
		if (move) begin
			nxt.q   = cur.q + terms.inc_b;
			nxt.mnr = terms.mnr_dec ? cur.mnr - coord_t'(1) : cur.mnr + coord_t'(1);
		end else begin
			nxt.q   = cur.q + terms.inc_a;
			nxt.mnr = cur.mnr;
		end
	end

endmodule

// ===== design/bresenham_line_rasterizer.sv =====
// Top level: command capture, set-up sequencer, pixel walk and output register.
// A command is accepted, set-up runs in ST_DIFF and then ST_INIT, then the walk gives one
// pixel word per cycle while the output is not stalled. A line gives N words, N being the
// longer extent of the line; no new command is taken until the line is done.
// A degenerate line produces no words.
// Reset (arst_n low, asynchronous) empties the output, returns to idle, and sets both image
// dimensions to 64.
module bresenham_line_rasterizer (
	input  logic                           clk,
	input  logic                           arst_n,
	// s_axis_tdata, from bit 0: x_start, y_start, x_end, y_end, color
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [blr_pkg::IN_BITS-1:0]    s_axis_tdata,
	// m_axis_tdata, from bit 0: pixel_x, pixel_y, pixel_color, zero padding
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [blr_pkg::OUT_BITS-1:0]   m_axis_tdata,
	output logic                           m_axis_tlast,
	// m_axis_tuser, from bit 0: visible
	output logic [0:0]                     m_axis_tuser,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [blr_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [blr_pkg::APB_BITS-1:0]   pwdata,
	output logic [blr_pkg::APB_BITS-1:0]   prdata,
	output logic                           pready
);
	import blr_pkg::*;

	blr_state_t state_q, state_d;

	dim_t width_q, height_q;

	coord_t xs_q, ys_q, xe_q, ye_q;
	color_t color_q;

	coord_t adx_q, ady_q;
	logic   xlt_q, xgt_q, ylt_q, dyz_q;

	blr_walk_t  walk_q, walk_nxt;
	blr_terms_t terms_q;
	logic       xmaj_q;
	coord_t     cnt_q;

	logic   out_valid_q;
	coord_t out_x_q, out_y_q;
	color_t out_color_q;
	logic   out_vis_q, out_last_q;

	logic accept, fire, cfg_wr;

	logic signed [COORD_BITS:0] ddx, ddy, adx_w, ady_w;

	logic   xmaj_w;
	coord_t len_w, mnr_len_w, maj0_w, mnr0_w;
	dec_t   m2_w, len1_w;
	coord_t px_w, py_w;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[DIM_BITS-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_BITS-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = APB_BITS'(width_q);
			REG_HEIGHT: prdata = APB_BITS'(height_q);
			default:    prdata = '0;
		endcase
	end

	// Handshakes.
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign fire          = (state_q == ST_RUN) && (!out_valid_q || m_axis_tready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: state_d = ST_INIT;
			ST_INIT: state_d = (len_w == '0) ? ST_IDLE : ST_RUN;
			ST_RUN: begin
				if (fire && cnt_q == coord_t'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Command capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			xs_q    <= s_axis_tdata[COORD_BITS-1:0];
			ys_q    <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
			xe_q    <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
			ye_q    <= s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
			color_q <= s_axis_tdata[IN_BITS-1:4*COORD_BITS];
		end
	end

	// First set-up step (ST_DIFF): endpoint differences, their magnitudes and direction flags.
	assign ddx   = signed'({1'b0, xe_q}) - signed'({1'b0, xs_q});
	assign ddy   = signed'({1'b0, ye_q}) - signed'({1'b0, ys_q});
	assign adx_w = ddx[COORD_BITS] ? -ddx : ddx;
	assign ady_w = ddy[COORD_BITS] ? -ddy : ddy;

	always_ff @(posedge clk) begin
		if (state_q == ST_DIFF) begin
			adx_q <= adx_w[COORD_BITS-1:0];
			ady_q <= ady_w[COORD_BITS-1:0];
			xlt_q <= (xs_q < xe_q);
			xgt_q <= (xs_q > xe_q);
			ylt_q <= (ys_q < ye_q);
			dyz_q <= (ys_q == ye_q);
		end
	end

	// Second set-up step (ST_INIT): pick the octant, the start point and the decision terms.
	// A horizontal line is walked as x-major with no minor movement, starting one left of
	// its left end so that the left end is drawn and the right end is not.
	assign xmaj_w = dyz_q || (ady_q <= adx_q);

	always_comb begin
		if (xmaj_w) begin
			len_w     = adx_q;
			mnr_len_w = dyz_q ? '0 : ady_q;
			if (dyz_q) begin
				maj0_w = (xlt_q ? xs_q : xe_q) - coord_t'(1);
				mnr0_w = ys_q;
			end else begin
				maj0_w = xlt_q ? xs_q : xe_q;
				mnr0_w = xlt_q ? ys_q : ye_q;
			end
		end else begin
			len_w     = ady_q;
			mnr_len_w = adx_q;
			maj0_w    = ylt_q ? ys_q : ye_q;
			mnr0_w    = ylt_q ? xs_q : xe_q;
		end
	end

	assign m2_w   = signed'({{(DEC_BITS-COORD_BITS-1){1'b0}}, mnr_len_w, 1'b0});
	assign len1_w = signed'({{(DEC_BITS-COORD_BITS){1'b0}}, len_w});

	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			xmaj_q        <= xmaj_w;
			cnt_q         <= len_w;
			walk_q.q      <= m2_w - len1_w;
			walk_q.maj    <= maj0_w;
			walk_q.mnr    <= mnr0_w;
			terms_q.inc_a <= m2_w;
			terms_q.inc_b <= m2_w - (len1_w <<< 1);
			terms_q.mnr_dec <= xmaj_w ? (xlt_q ^ ylt_q) : (ylt_q ? xgt_q : xlt_q);
		end else if (fire) begin
			walk_q <= walk_nxt;
			cnt_q  <= cnt_q - coord_t'(1);
		end
	end

	blr_step_unit u_step (
		.cur   (walk_q),
		.terms (terms_q),
		.nxt   (walk_nxt)
	);

	// Output register.
	assign px_w = xmaj_q ? walk_nxt.maj : walk_nxt.mnr;
	assign py_w = xmaj_q ? walk_nxt.mnr : walk_nxt.maj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_x_q     <= px_w;
			out_y_q     <= py_w;
			out_color_q <= color_q;
			out_vis_q   <= (DIM_BITS'(px_w) < width_q) && (DIM_BITS'(py_w) < height_q);
			out_last_q  <= (cnt_q == coord_t'(1));
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_BITS'({out_color_q, out_y_q, out_x_q});
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_vis_q;

endmodule

// ===== design/blr_checker.sv =====
// Port-level checks of the line rasteriser, bound to the top level.
module blr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [blr_pkg::OUT_BITS-1:0]  m_axis_tdata,
	input logic                          m_axis_tlast,
	input logic [0:0]                    m_axis_tuser
);
	import blr_pkg::*;

	// A stalled word must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
		&& $stable(m_axis_tuser))
		else $error("stalled output word changed");

	// After a command is taken the block is busy for at least the set-up cycles.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
		else $error("command accepted during set-up");

	// While a word that is not the last of its line waits, the line is still being walked.
	a_mid_line_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("ready for a command in the middle of a line");

	// No word appears in the cycle after a command is taken unless one was already waiting.
	a_no_early_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (!m_axis_tvalid || m_axis_tready)
		|=> !m_axis_tvalid)
		else $error("output word before set-up finished");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
